// File: src/fncl_pkg.sv
// Shared types and constants for the FAT next-cluster lookup block.
// Used by the controller, the datapath, the top level and the checker.
package fncl_pkg;

    localparam int CLUSTER_W  = 28;
    localparam int FILL_OFF_W = 11;
    localparam int OFF_W      = 30;    // cluster number times four
    localparam int FILL_SPAN  = 2048;  // bytes a fill offset can address
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    localparam logic [1:0] FAT_12 = 2'd0;
    localparam logic [1:0] FAT_16 = 2'd1;
    localparam logic [1:0] FAT_32 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FAT_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

    localparam logic [11:0] FAT12_MASK = 12'hFFF;
    localparam logic [11:0] FAT12_EOC  = 12'hFF8;
    localparam logic [31:0] FAT12_EXT  = 32'hFFFFF000;
    localparam logic [15:0] FAT16_EOC  = 16'hFFF8;
    localparam logic [31:0] FAT16_EXT  = 32'hFFFF0000;

    typedef struct packed {
        logic                  req_type;
        logic [CLUSTER_W-1:0]  cluster;
        logic [FILL_OFF_W-1:0] fill_offset;
        logic [7:0]            fill_byte;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] next_cluster;
        logic [31:0] fetch_sector;
    } rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_OFFSET  = 6'b000010,
        ST_CHECK   = 6'b000100,
        ST_FETCH   = 6'b001000,
        ST_EXTRACT = 6'b010000,
        ST_OUT     = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic offset_en;
        logic check_en;
        logic read_en;
        logic extract_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic chk_hit;
    } dp_status_t;

endpackage

// File: src/fat_next_cluster_lookup_unit.sv
// FAT next-cluster lookup: top level joining the controller and the datapath.
// Depends on fncl_pkg, fncl_ctrl, fncl_dp.
//
// A fill transaction (req_type 1) writes one byte into the cache window;
// req_stall stays low. A lookup transaction (req_type 0) raises req_stall
// until its result has been taken: rsp_valid rises after the offset and
// window-check states on a miss, and after those and a fetch (one read of
// the four byte-lane cache banks) and extraction on a hit. On a miss the
// window moves to the entry's sector and fetch_sector names the first
// device sector to load; fill the window and repeat the lookup. The cache
// needs no clearing after reset: the first lookup always misses.
// SECTOR_BYTES must be a power of two.
module fat_next_cluster_lookup_unit
    import fncl_pkg::*;
#(
    parameter int SECTOR_BYTES  = 512,
    parameter int CACHE_SECTORS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       busy;
    logic       req_fire;
    logic       lookup_start;

    assign cfg_ready    = 1'b1;
    assign req_stall    = busy;
    assign req_fire     = req_valid && !busy;
    assign lookup_start = req_fire && (req.req_type == REQ_LOOKUP);

    fncl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_start (lookup_start),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .rsp_valid    (rsp_valid)
    );

    fncl_dp #(
        .SECTOR_BYTES  (SECTOR_BYTES),
        .CACHE_SECTORS (CACHE_SECTORS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_fire  (req_fire),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule

// File: src/fncl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fncl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fncl_ctrl.sv
// Sequencing state machine for one lookup transaction.
// Depends on fncl_pkg for the state type and the command/status structs.
module fncl_ctrl
    import fncl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       lookup_start,
    input  logic       rsp_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       rsp_valid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_start)
                begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET:  state_next = ST_CHECK;
            ST_CHECK:   state_next = status.chk_hit ? ST_FETCH : ST_OUT;
            ST_FETCH:   state_next = ST_EXTRACT;
            ST_EXTRACT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load       = (state_reg == ST_IDLE) && lookup_start;
        cmd.offset_en  = (state_reg == ST_OFFSET);
        cmd.check_en   = (state_reg == ST_CHECK);
        cmd.read_en    = (state_reg == ST_FETCH);
        cmd.extract_en = (state_reg == ST_EXTRACT);
    end

    assign busy      = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);

endmodule

// File: src/fncl_dp.sv
// Datapath: configuration registers, window tracking, offset arithmetic,
// four byte-lane cache banks and entry extraction. Depends on fncl_pkg, fncl_ram.
module fncl_dp
    import fncl_pkg::*;
#(
    parameter int SECTOR_BYTES  = 512,
    parameter int CACHE_SECTORS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_fire,
    input  req_t                  req,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output rsp_t                  rsp
);

    localparam int SB_W         = $clog2(SECTOR_BYTES);
    localparam int SECT_W       = OFF_W - SB_W;
    localparam int CS_W         = (CACHE_SECTORS > 1) ? $clog2(CACHE_SECTORS) : 1;
    localparam int WINDOW_BYTES = SECTOR_BYTES * CACHE_SECTORS;
    localparam int LOC_W        = $clog2(WINDOW_BYTES) + 1;
    localparam int CACHE_DEPTH  = (WINDOW_BYTES < FILL_SPAN) ? WINDOW_BYTES : FILL_SPAN;
    localparam int IDX_W        = $clog2(CACHE_DEPTH);
    localparam int BANK_DEPTH   = CACHE_DEPTH / 4;
    localparam int BANK_AW      = IDX_W - 2;

    logic [1:0]           fat_type_reg;
    logic [15:0]          reserved_reg;
    logic                 window_valid_reg;
    logic [SECT_W-1:0]    window_reg;
    logic [CLUSTER_W-1:0] clus_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [OFF_W-1:0]     off_next;
    logic [LOC_W-1:0]     local_reg;
    rsp_t                 result_reg;

    logic [SECT_W-1:0]    sector;
    logic [SECT_W-1:0]    diff;
    logic                 in_window;
    logic [LOC_W-1:0]     local_pos;
    logic [LOC_W-1:0]     local_end;
    logic [LOC_W-1:0]     entry_bytes;
    logic                 chk_hit;

    logic                 fill_we;
    logic [IDX_W-1:0]     rd_idx;
    logic [BANK_AW-1:0]   rd_word;
    logic [BANK_AW-1:0]   rd_word_inc;
    logic [7:0]           bank_rdata [4];
    logic [7:0]           entry_byte [4];
    logic [15:0]          half_word;
    logic [11:0]          fat12_val;
    logic [31:0]          entry_val;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_type_reg <= FAT_12;
            reserved_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FAT_TYPE: fat_type_reg <= cfg_data[1:0];
                CFG_RESERVED: reserved_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // FAT byte offset of the entry
    always_comb
    begin
        case (fat_type_reg)
            FAT_12:  off_next = (OFF_W'(clus_reg) + OFF_W'({clus_reg, 1'b0})) >> 1;
            FAT_16:  off_next = OFF_W'({clus_reg, 1'b0});
            default: off_next = {clus_reg, 2'b00};
        endcase
    end

    // Window check
    always_comb
    begin
        sector      = off_reg[OFF_W-1:SB_W];
        diff        = sector - window_reg;
        in_window   = window_valid_reg && (sector >= window_reg)
                      && (diff < SECT_W'(CACHE_SECTORS));
        local_pos   = (LOC_W'(diff[CS_W-1:0]) << SB_W) | LOC_W'(off_reg[SB_W-1:0]);
        entry_bytes = (fat_type_reg == FAT_12 || fat_type_reg == FAT_16)
                      ? LOC_W'(2) : LOC_W'(4);
        local_end   = local_pos + entry_bytes;
        // an entry running past the window end is a miss
        chk_hit     = in_window && (local_end <= LOC_W'(WINDOW_BYTES));
    end

    assign status.chk_hit = chk_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_valid_reg <= 1'b0;
        end
        else if (cmd.check_en && !chk_hit)
        begin
            window_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clus_reg <= req.cluster;
        end
        if (cmd.offset_en)
        begin
            off_reg <= off_next;
        end
        if (cmd.check_en)
        begin
            local_reg <= local_pos;
            if (!chk_hit)
            begin
                window_reg              <= sector;
                result_reg.hit          <= 1'b0;
                result_reg.next_cluster <= '0;
                result_reg.fetch_sector <= 32'(reserved_reg) + 32'(sector);
            end
        end
        if (cmd.extract_en)
        begin
            result_reg.hit          <= 1'b1;
            result_reg.next_cluster <= entry_val;
            result_reg.fetch_sector <= '0;
        end
    end

    // Cache banks, one per byte lane; an entry needs at most one read per lane
    assign fill_we = req_fire && (req.req_type == REQ_FILL)
                     && (32'(req.fill_offset) < 32'(WINDOW_BYTES));

    assign rd_idx      = local_reg[IDX_W-1:0];
    assign rd_word     = rd_idx[IDX_W-1:2];
    assign rd_word_inc = rd_word + BANK_AW'(1);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        fncl_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (fill_we && (req.fill_offset[1:0] == 2'(b))),
            .waddr (req.fill_offset[IDX_W-1:2]),
            .wdata (req.fill_byte),
            .re    (cmd.read_en),
            .raddr ((2'(b) < rd_idx[1:0]) ? rd_word_inc : rd_word),
            .rdata (bank_rdata[b])
        );
    end

    // Entry extraction, little-endian from the starting lane
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            entry_byte[k] = bank_rdata[2'(local_reg[1:0] + 2'(k))];
        end
        half_word = {entry_byte[1], entry_byte[0]};
        fat12_val = clus_reg[0] ? half_word[15:4] : (half_word[11:0] & FAT12_MASK);
        case (fat_type_reg)
            FAT_12:
            begin
                entry_val = 32'(fat12_val);
                if (fat12_val >= FAT12_EOC)
                begin
                    entry_val = entry_val | FAT12_EXT;
                end
            end
            FAT_16:
            begin
                entry_val = 32'(half_word);
                if (half_word >= FAT16_EOC)
                begin
                    entry_val = entry_val | FAT16_EXT;
                end
            end
            default:
            begin
                entry_val = {entry_byte[3], entry_byte[2], entry_byte[1], entry_byte[0]};
            end
        endcase
    end

    assign rsp = result_reg;

endmodule

// File: src/fncl_checker.sv
// Port-level checks for the FAT next-cluster lookup block, bound to the top.
// Depends on fncl_pkg and fat_next_cluster_lookup_unit.
module fncl_checker
    import fncl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == REQ_LOOKUP |=> req_stall)
        else $error("lookup accepted without going busy");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == REQ_FILL |=> !req_stall && !rsp_valid)
        else $error("fill transaction left the block busy");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request taken while a result is pending");

    a_rsp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.hit && rsp.fetch_sector == 32'd0)
                   || (!rsp.hit && rsp.next_cluster == 32'd0))
        else $error("unused result field not zero");

endmodule

bind fat_next_cluster_lookup_unit fncl_checker u_fncl_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for fat_next_cluster_lookup_unit: directed and random lookups and fills.
// Depends on fncl_pkg and the RTL under src/; a local predictor supplies the expected results.
module tb
    import fncl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SECTOR_BYTES  = 512;
    localparam int          CACHE_SECTORS = 4;
    localparam int          WIN_BYTES     = SECTOR_BYTES * CACHE_SECTORS;
    localparam logic [31:0] NO_WINDOW     = 32'hFFFFFFFF;
    localparam logic [1:0]  FAT_UNUSED    = 2'd3;
    localparam int          IDLE_PCT      = 19;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          PHASE_ITEMS   = 190;
    localparam int          MAX_REPORTS   = 50;

    logic                  clk = 1'b1;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;

    // predictor state and configuration copy
    logic [7:0]  cache_mem [WIN_BYTES];
    logic [31:0] win_sector = NO_WINDOW;
    logic [1:0]  cur_fat = FAT_12;
    logic [15:0] cur_reserved = '0;

    // stimulus planning: window position and which cache bytes hold data
    logic [31:0] plan_win = NO_WINDOW;
    bit          plan_written [WIN_BYTES];

    req_t fat_req_q [$];
    rsp_t link_exp_q [$];
    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_checked = 0;
    int   n_errors = 0;
    int   hold_count = 0;
    bit   quiet = 1'b0;
    bit   hold_rsp = 1'b0;

    fat_next_cluster_lookup_unit #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .CACHE_SECTORS(CACHE_SECTORS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    function automatic void entry_pos(input logic [27:0] clus, output logic [63:0] off,
                                      output int width);
        case (cur_fat)
            FAT_12:
            begin
                off   = (64'(clus) * 3) / 2;
                width = 2;
            end
            FAT_16:
            begin
                off   = 64'(clus) * 2;
                width = 2;
            end
            default:
            begin
                off   = 64'(clus) * 4;
                width = 4;
            end
        endcase
    endfunction

    // every byte of the entry must sit inside the window held
    function automatic bit window_hit(input logic [31:0] win, input logic [63:0] off,
                                      input int width, output logic [63:0] loc);
        logic [63:0] sec;
        sec = off / SECTOR_BYTES;
        loc = '0;
        if (win == NO_WINDOW || sec < 64'(win) || sec >= 64'(win) + CACHE_SECTORS)
            return 1'b0;
        loc = off - 64'(win) * SECTOR_BYTES;
        return (loc + width <= WIN_BYTES);
    endfunction

    function automatic void predict_chain_link(input req_t r);
        logic [63:0] off;
        logic [63:0] loc;
        int          width;
        logic [31:0] w;
        logic [31:0] val;
        rsp_t        e;
        if (r.req_type == REQ_FILL)
        begin
            cache_mem[r.fill_offset] = r.fill_byte;
            return;
        end
        entry_pos(r.cluster, off, width);
        e = '0;
        if (!window_hit(win_sector, off, width, loc))
        begin
            win_sector     = 32'(off / SECTOR_BYTES);
            e.fetch_sector = {16'h0, cur_reserved} + win_sector;
        end
        else
        begin
            w = '0;
            for (int i = 0; i < width; i++)
                w[8*i +: 8] = cache_mem[loc + i];
            case (cur_fat)
                FAT_12:
                begin
                    val = r.cluster[0] ? {20'h0, w[15:4]} : {20'h0, w[11:0] & FAT12_MASK};
                    if (val[11:0] >= FAT12_EOC)
                        val = val | FAT12_EXT;
                end
                FAT_16:
                begin
                    val = {16'h0, w[15:0]};
                    if (val[15:0] >= FAT16_EOC)
                        val = val | FAT16_EXT;
                end
                default:
                    val = w;
            endcase
            e.hit          = 1'b1;
            e.next_cluster = val;
        end
        link_exp_q.push_back(e);
    endfunction

    function automatic void push_req(input req_t r);
        fat_req_q.push_back(r);
        n_queued++;
    endfunction

    function automatic void plan_fill(input logic [10:0] pos, input logic [7:0] data);
        req_t r;
        r.req_type    = REQ_FILL;
        r.cluster     = 28'($urandom);
        r.fill_offset = pos;
        r.fill_byte   = data;
        plan_written[pos] = 1'b1;
        push_req(r);
    endfunction

    // a hit never reads a byte that holds nothing: fill any such byte first
    function automatic void plan_lookup(input logic [27:0] clus);
        logic [63:0] off;
        logic [63:0] loc;
        int          width;
        req_t        r;
        entry_pos(clus, off, width);
        if (window_hit(plan_win, off, width, loc))
        begin
            for (int i = 0; i < width; i++)
                if (!plan_written[loc + i])
                    plan_fill(11'(loc + i), 8'($urandom));
        end
        else
            plan_win = 32'(off / SECTOR_BYTES);
        r.req_type    = REQ_LOOKUP;
        r.cluster     = clus;
        r.fill_offset = 11'($urandom);
        r.fill_byte   = 8'($urandom);
        push_req(r);
    endfunction

    // miss if need be, write the entry bytes as the host would, then look up again
    function automatic void plan_link(input logic [27:0] clus, input logic [31:0] val);
        logic [63:0] off;
        logic [63:0] loc;
        int          width;
        logic [31:0] w;
        entry_pos(clus, off, width);
        if (!window_hit(plan_win, off, width, loc))
        begin
            plan_lookup(clus);
            void'(window_hit(plan_win, off, width, loc));
        end
        case (cur_fat)
            FAT_12:  w = clus[0] ? {16'h0, val[11:0], 4'($urandom)}
                                 : {16'h0, 4'($urandom), val[11:0]};
            FAT_16:  w = {16'h0, val[15:0]};
            default: w = val;
        endcase
        for (int i = 0; i < width; i++)
            plan_fill(11'(loc + i), w[8*i +: 8]);
        plan_lookup(clus);
    endfunction

    function automatic logic [31:0] link_value();
        int pick;
        pick = $urandom_range(99);
        case (cur_fat)
            FAT_12:
                if (pick < 25)
                    return {20'h0, FAT12_EOC} + $urandom_range(7);
                else if (pick < 35)
                    return {20'h0, FAT12_EOC} - 1;
                else
                    return 32'($urandom_range(12'hFFF));
            FAT_16:
                if (pick < 25)
                    return {16'h0, FAT16_EOC} + $urandom_range(7);
                else if (pick < 35)
                    return {16'h0, FAT16_EOC} - 1;
                else
                    return 32'($urandom_range(16'hFFFF));
            default:
                if (pick < 10)
                    return 32'hFFFFFFFF;
                else if (pick < 20)
                    return 32'h0FFFFFF8;
                else
                    return $urandom;
        endcase
    endfunction

    // cluster whose entry lies in the current window, or against its far end
    function automatic logic [27:0] near_window(input bit at_end);
        logic [31:0] win;
        logic [63:0] b;
        win = (plan_win == NO_WINDOW) ? 32'h0 : plan_win;
        b   = 64'(win) * SECTOR_BYTES;
        if (at_end)
            b = b + WIN_BYTES - 1 - $urandom_range(3);
        else
            b = b + $urandom_range(WIN_BYTES - 1);
        case (cur_fat)
            FAT_12:  return 28'((b * 2) / 3 + $urandom_range(1));
            FAT_16:  return 28'(b / 2);
            default: return 28'(b / 4);
        endcase
    endfunction

    function automatic logic [27:0] any_cluster();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 28'($urandom_range(4095));
        else if (pick < 85)
            return near_window(1'b0);
        else
            return 28'($urandom);
    endfunction

    function automatic void random_items(input int count);
        int stop;
        int pick;
        stop = n_queued + count;
        while (n_queued < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                plan_link(any_cluster(), link_value());
            else if (pick < 65)
                plan_lookup(near_window(1'b0));
            else if (pick < 75)
                plan_fill(11'($urandom), 8'($urandom));
            else if (pick < 88)
                plan_lookup(28'($urandom));
            else
                plan_lookup(near_window(1'b1));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FAT_TYPE: cur_fat = data[1:0];
            CFG_RESERVED: cur_reserved = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || link_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver: hold the transaction while stalled, then advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_chain_link(req);
                n_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (fat_req_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    req       <= fat_req_q.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, with one long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_rsp && hold_count < HOLD_CYCLES)
        begin
            rsp_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (link_exp_q.size() == 0)
                report_error($sformatf("result %0d arrived with no lookup pending", n_checked));
            else
            begin
                want = link_exp_q.pop_front();
                if (rsp.hit !== want.hit)
                    report_error($sformatf("result %0d hit: got %b, expected %b",
                                           n_checked, rsp.hit, want.hit));
                if (rsp.next_cluster !== want.next_cluster)
                    report_error($sformatf("result %0d next_cluster: got %h, expected %h",
                                           n_checked, rsp.next_cluster, want.next_cluster));
                if (rsp.fetch_sector !== want.fetch_sector)
                    report_error($sformatf("result %0d fetch_sector: got %h, expected %h",
                                           n_checked, rsp.fetch_sector, want.fetch_sector));
            end
            n_checked++;
        end
    end

    initial
    begin
        #2ms;
        $display("** fat_next_cluster_lookup_unit: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // FAT12, no idling on either side
        quiet = 1'b1;
        write_reg(CFG_FAT_TYPE, {14'h0, FAT_12});
        write_reg(CFG_RESERVED, 16'h0000);
        plan_lookup(28'd0);
        plan_link(28'd0, {20'h0, FAT12_EOC});
        plan_link(28'd3, {20'h0, FAT12_EOC} - 1);
        plan_link(28'd1364, 32'h0ABC);
        plan_lookup(28'd1365);
        plan_lookup(28'hFFFFFFF);
        random_items(PHASE_ITEMS);
        wait_drained();
        quiet = 1'b0;

        write_reg(CFG_FAT_TYPE, {14'h0, FAT_16});
        write_reg(CFG_RESERVED, 16'hFFFF);
        plan_link(28'd5, {16'h0, FAT16_EOC});
        plan_link(28'd6, {16'h0, FAT16_EOC} - 1);
        random_items(PHASE_ITEMS);
        wait_drained();

        // FAT32 with the result side held off while requests keep coming
        write_reg(CFG_FAT_TYPE, {14'h0, FAT_32});
        write_reg(CFG_RESERVED, 16'($urandom));
        hold_rsp = 1'b1;
        plan_link(28'd7, 32'hFFFFFFFF);
        plan_link(28'd8, 32'h0);
        random_items(PHASE_ITEMS);
        wait_drained();

        write_reg(CFG_FAT_TYPE, {14'h0, FAT_UNUSED});
        write_reg(CFG_RESERVED, 16'($urandom));
        random_items(PHASE_ITEMS);
        wait_drained();

        write_reg(CFG_FAT_TYPE, {14'h0, FAT_12});
        write_reg(CFG_RESERVED, 16'hFFFF);
        random_items(PHASE_ITEMS);
        wait_drained();

        if (n_errors == 0)
            $display("** fat_next_cluster_lookup_unit: PASSED **");
        else
            $display("** fat_next_cluster_lookup_unit: FAILED **");
        $finish;
    end

endmodule
